/* rtl/core/sha_pkg.sv */
`timescale 1ns / 1ps
package sha_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DATA,
    S_PAD,
    S_ROUND,
    S_ADD,
    S_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic take;      // capture input transaction
    logic put_data;  // append next message byte
    logic put_pad;   // append next padding / length byte
    logic round;     // one compression round
    logic add;       // fold working variables into chain value
    logic out_ack;   // digest part taken
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic bytes_left;  // message bytes of current item still to append
    logic last;        // current item closes the message
    logic pos_end;     // next byte lands in the final slot of the block
    logic padding;     // padding has begun
    logic done;        // final block has been queued for compression
    logic rnd_last;    // round 63
    logic part_last;   // digest part 3 on the output
  } sts_t;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] ror32(input logic [31:0] x, input logic [4:0] n);
    ror32 = (x >> n) | (x << (6'd32 - {1'b0, n}));
  endfunction

endpackage

/* rtl/core/sha_ctrl.sv */
`timescale 1ns / 1ps
module sha_ctrl import sha_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  input  logic   out_stall_i,
  input  sts_t   sts_i,
  output cmd_t   cmd_o,
  output logic   in_stall_o,
  output logic   out_valid_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DATA;
      end
      S_DATA: begin
        if (!sts_i.bytes_left) begin
          state_d = sts_i.last ? S_PAD : S_IDLE;
        end else if (sts_i.pos_end) begin
          state_d = S_ROUND;
        end
      end
      S_PAD: begin
        if (sts_i.pos_end) state_d = S_ROUND;
      end
      S_ROUND: begin
        if (sts_i.rnd_last) state_d = S_ADD;
      end
      S_ADD: begin
        if (sts_i.done)            state_d = S_OUT;
        else if (sts_i.padding)    state_d = S_PAD;
        else if (sts_i.bytes_left) state_d = S_DATA;
        else if (sts_i.last)       state_d = S_PAD;
        else                       state_d = S_IDLE;
      end
      S_OUT: begin
        if (!out_stall_i && sts_i.part_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.take = in_valid_i;
      end
      S_DATA:  cmd_o.put_data = sts_i.bytes_left;
      S_PAD:   cmd_o.put_pad  = 1'b1;
      S_ROUND: cmd_o.round    = 1'b1;
      S_ADD:   cmd_o.add      = 1'b1;
      S_OUT: begin
        out_valid_o   = 1'b1;
        cmd_o.out_ack = !out_stall_i;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/sha_dp.sv */
`timescale 1ns / 1ps
module sha_dp import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        last_i,
  output sts_t        sts_o,
  output logic [63:0] digest_part_o,
  output logic [1:0]  part_index_o,
  output logic        last_part_o
);

  logic [31:0] item_q;
  logic [2:0]  rem_q;
  logic        last_q;
  logic [63:0] len_q;
  logic [5:0]  fill_q;
  logic [23:0] acc_q;
  logic        pad_q, extra_q, done_q;
  logic [5:0]  rnd_q;
  logic [1:0]  part_q;
  logic [31:0] w_q [16];
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];

  logic [2:0]  cnt;
  logic        put;
  logic [7:0]  byte_v, len_byte;
  logic [31:0] word_v, s0, s1, w_new;
  logic [31:0] bs0, bs1, ch, maj, t1, t2;

  assign cnt = (byte_count_i > 3'd4) ? 3'd4 : byte_count_i;
  assign put = cmd_i.put_data | cmd_i.put_pad;

  assign len_byte = 8'(len_q >> {~fill_q[2:0], 3'b000});

  always_comb begin
    if (cmd_i.put_data)                       byte_v = item_q[31:24];
    else if (!pad_q)                          byte_v = PadByte;
    else if (fill_q >= LenPos && !extra_q)    byte_v = len_byte;
    else                                      byte_v = 8'h00;
  end
  assign word_v = {acc_q, byte_v};

  // message schedule and round function
  assign s0    = ror32(w_q[1], 5'd7) ^ ror32(w_q[1], 5'd18) ^ (w_q[1] >> 3);
  assign s1    = ror32(w_q[14], 5'd17) ^ ror32(w_q[14], 5'd19) ^ (w_q[14] >> 10);
  assign w_new = s1 + w_q[9] + s0 + w_q[0];
  assign bs1   = ror32(v_q[4], 5'd6) ^ ror32(v_q[4], 5'd11) ^ ror32(v_q[4], 5'd25);
  assign ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign t1    = v_q[7] + bs1 + ch + RoundK[rnd_q] + w_q[0];
  assign bs0   = ror32(v_q[0], 5'd2) ^ ror32(v_q[0], 5'd13) ^ ror32(v_q[0], 5'd22);
  assign maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t2    = bs0 + maj;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= '0;
      last_q  <= 1'b0;
      len_q   <= '0;
      fill_q  <= '0;
      pad_q   <= 1'b0;
      extra_q <= 1'b0;
      done_q  <= 1'b0;
      rnd_q   <= '0;
      part_q  <= '0;
      h_q     <= InitH;
    end else begin
      if (cmd_i.take) begin
        rem_q  <= cnt;
        last_q <= last_i;
        len_q  <= len_q + {58'd0, cnt, 3'b000};
      end
      if (cmd_i.put_data) rem_q <= rem_q - 3'd1;
      if (put) fill_q <= fill_q + 6'd1;
      if (cmd_i.put_pad) begin
        pad_q <= 1'b1;
        if (fill_q == 6'd63) begin
          extra_q <= 1'b0;
          if (pad_q && !extra_q) done_q <= 1'b1;
        end else if (!pad_q && fill_q >= LenPos) begin
          extra_q <= 1'b1;
        end
      end
      if (cmd_i.round) rnd_q <= rnd_q + 6'd1;
      if (cmd_i.add) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      if (cmd_i.out_ack) begin
        part_q <= part_q + 2'd1;
        if (part_q == 2'd3) begin
          // message finished: back to the initial state
          h_q     <= InitH;
          len_q   <= '0;
          fill_q  <= '0;
          pad_q   <= 1'b0;
          extra_q <= 1'b0;
          done_q  <= 1'b0;
          last_q  <= 1'b0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) item_q <= data_word_i;
    if (cmd_i.put_data) item_q <= {item_q[23:0], 8'h00};
    if (put) begin
      acc_q <= word_v[23:0];
      if (fill_q[1:0] == 2'd3) begin
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
        w_q[15] <= word_v;
      end
      if (fill_q == 6'd63) v_q <= h_q;
    end
    if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
      w_q[15] <= w_new;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  assign sts_o.bytes_left = (rem_q != 3'd0);
  assign sts_o.last       = last_q;
  assign sts_o.pos_end    = (fill_q == 6'd63);
  assign sts_o.padding    = pad_q;
  assign sts_o.done       = done_q;
  assign sts_o.rnd_last   = (rnd_q == 6'd63);
  assign sts_o.part_last  = (part_q == 2'd3);

  assign digest_part_o = {h_q[{part_q, 1'b0}], h_q[{part_q, 1'b1}]};
  assign part_index_o  = part_q;
  assign last_part_o   = (part_q == 2'd3);

endmodule

/* rtl/core/sha256_hash_engine.sv */
`timescale 1ns / 1ps
// Channel   Handshake               Payload
// input     in_valid_i / in_stall_o  data_word_i[31:0], byte_count_i[2:0], last_i
// output    out_valid_o / out_stall_i digest_part_o[63:0], part_index_o[1:0], last_part_o
//
// One transaction at a time. A word is captured and its bytes are appended one by one;
// a word that is not the last then returns the engine to idle. The byte that fills a
// block starts 64 rounds of the single round unit, then the fold. A last word pads byte
// by byte (one or two compressions) before four digest parts appear, one per cycle
// unless stalled.
// Reset (rst_ni low, asynchronous) loads the initial hash and clears length and fill.
// Input stall is high whenever the engine is busy; output stall just holds the part.
module sha256_hash_engine import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] digest_part_o,
  output logic [1:0]  part_index_o,
  output logic        last_part_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: byte feed, padding, rounds and digest readout
  sha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  // block buffer, schedule, working variables, chain value
  sha_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_word_i   (data_word_i),
    .byte_count_i  (byte_count_i),
    .last_i        (last_i),
    .sts_o         (sts),
    .digest_part_o (digest_part_o),
    .part_index_o  (part_index_o),
    .last_part_o   (last_part_o)
  );

endmodule

/* rtl/core/sha_chk.sv */
`timescale 1ns / 1ps
module sha_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] digest_part_o,
  input logic [1:0]  part_index_o,
  input logic        last_part_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(digest_part_o)
      && $stable(part_index_o))
    else $error("stalled digest part changed");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while digest pending");

  a_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_part_o |=>
      out_valid_o && part_index_o == $past(part_index_o) + 2'd1)
    else $error("digest parts out of sequence");

  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_part_o |=> !out_valid_o && !in_stall_o)
    else $error("engine not idle after final part");

endmodule

bind sha256_hash_engine sha_chk u_sha_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .digest_part_o (digest_part_o),
  .part_index_o  (part_index_o),
  .last_part_o   (last_part_o)
);
